// File: rtl/peak_meter_envelope_unit_defines.svh
// ----------------------------------------------------------------------------
// Peak meter envelope unit assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PEAK_METER_ENVELOPE_UNIT_DEFINES_SVH
`define PEAK_METER_ENVELOPE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PME_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PME_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/pme_pkg.sv
// ----------------------------------------------------------------------------
// Peak meter envelope package
// Field widths, register indexes, reset values and parameter defaults.
// ----------------------------------------------------------------------------
package pme_pkg;

	localparam int CHAN_W = 3;
	localparam int ACT_W = 4;
	localparam int CFG_IDX_W = 2;

	localparam int DEF_CHANNELS = 8;
	localparam int DEF_SAMPLE_BITS = 24;
	localparam int DEF_COEF_BITS = 24;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [ACT_W-1:0] ACTIVE_CHANNELS_RESET = 4'd2;
	localparam int RELEASE_COEF_RESET = 538;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACTIVE_CHANNELS = 2'd0,
		CFG_RELEASE_COEF = 2'd1
	} cfg_reg_t;

endpackage

// File: rtl/pme_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pme_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/pme_front.sv
// ----------------------------------------------------------------------------
// Peak meter front end
// Accepts samples, takes their magnitude and checks the channel index.
// ----------------------------------------------------------------------------
module pme_front import pme_pkg::*; #(
	parameter int CHANNELS = DEF_CHANNELS,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                   sample_valid,
	output logic                   sample_ready,
	input  logic [CHAN_W-1:0]      chan,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [ACT_W-1:0]       active_channels,
	input  logic                   push_ready,
	output logic                   push,
	output logic [CHAN_W-1:0]      push_chan,
	output logic [SAMPLE_BITS-1:0] push_mag,
	output logic                   push_ok
);

	logic [SAMPLE_BITS-1:0] neg_sample;

	// The most negative sample wraps to 2^(SAMPLE_BITS-1), which is its magnitude.
	assign neg_sample = ~sample + SAMPLE_BITS'(1);

	always_comb begin
		push_chan = chan;
		push_mag = sample[SAMPLE_BITS-1] ? neg_sample : sample;
		push_ok = (ACT_W'(chan) < active_channels) && (int'(chan) < CHANNELS);
	end

	assign sample_ready = push_ready;
	assign push = sample_valid && push_ready;

endmodule

// File: rtl/pme_queue.sv
// ----------------------------------------------------------------------------
// Peak meter item queue
// Short register queue that decouples the front end from the envelope path.
// ----------------------------------------------------------------------------
module pme_queue import pme_pkg::*; #(
	parameter int WIDTH = 28,
	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             push_ready,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);

	logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      count_q;

	assign push_ready = (count_q < (PW+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + (PW+1)'(1);
				2'b01: count_q <= count_q - (PW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/pme_back.sv
// ----------------------------------------------------------------------------
// Peak meter envelope path
// Reads the channel envelope, applies instant attack or exponential release,
// writes it back and holds the result in the output register.
// ----------------------------------------------------------------------------
`include "peak_meter_envelope_unit_defines.svh"

module pme_back import pme_pkg::*; #(
	parameter int CHANNELS = DEF_CHANNELS,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int COEF_BITS = DEF_COEF_BITS,
	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   head_valid,
	input  logic [CHAN_W-1:0]      head_chan,
	input  logic [SAMPLE_BITS-1:0] head_mag,
	input  logic                   head_ok,
	output logic                   pop,
	input  logic [COEF_BITS-1:0]   release_coef,
	output logic                   result_valid,
	input  logic                   result_ready,
	output logic [CHAN_W-1:0]      out_chan,
	output logic [SAMPLE_BITS-1:0] level,
	output logic                   chan_valid
);

	logic [CHAN_W+IDX_W-1:0] chan_ext;
	logic [IDX_W-1:0]        head_idx;
	logic                    hazard;
	logic                    out_free;
	logic                    adv_s2;
	logic                    s2_free;
	logic                    adv_s1;
	logic                    s1_free;
	logic                    issue;
	logic                    ram_re;
	logic                    ram_we;
	logic [SAMPLE_BITS-1:0]  ram_rdata;
	logic [CHANNELS-1:0]     env_vld_q;

	logic                    vld_s1;
	logic [CHAN_W-1:0]       chan_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic [SAMPLE_BITS-1:0]  mag_s1;
	logic                    ok_s1;
	logic                    evld_s1;
	logic [SAMPLE_BITS-1:0]  env_rd;
	logic                    attack;
	logic [SAMPLE_BITS-1:0]  diff;

	logic                    vld_s2;
	logic [CHAN_W-1:0]       chan_s2;
	logic [IDX_W-1:0]        idx_s2;
	logic [SAMPLE_BITS-1:0]  mag_s2;
	logic                    ok_s2;
	logic                    attack_s2;
	logic [SAMPLE_BITS-1:0]  env_s2;
	logic [SAMPLE_BITS-1:0]  diff_s2;
	logic [COEF_BITS+SAMPLE_BITS-1:0] prod;
	logic [SAMPLE_BITS-1:0]  step;
	logic [SAMPLE_BITS-1:0]  env_new;

	logic                    result_vld_q;
	logic [CHAN_W-1:0]       out_chan_q;
	logic [SAMPLE_BITS-1:0]  level_q;
	logic                    chan_valid_q;

	assign chan_ext = (CHAN_W+IDX_W)'(head_chan);
	assign head_idx = chan_ext[IDX_W-1:0];

	// A channel still being updated in either stage must finish before it is read again.
	assign hazard = head_ok && ((vld_s1 && ok_s1 && (idx_s1 == head_idx)) ||
		(vld_s2 && ok_s2 && (idx_s2 == head_idx)));

	assign out_free = !result_vld_q || result_ready;
	assign adv_s2 = vld_s2 && out_free;
	assign s2_free = !vld_s2 || adv_s2;
	assign adv_s1 = vld_s1 && s2_free;
	assign s1_free = !vld_s1 || adv_s1;
	assign issue = head_valid && s1_free && !hazard;
	assign pop = issue;

	assign ram_re = issue && head_ok;
	assign ram_we = adv_s2 && ok_s2;

	pme_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(CHANNELS)
	) u_env_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(idx_s2),
		.wdata(env_new),
		.re(ram_re),
		.raddr(head_idx),
		.rdata(ram_rdata)
	);

	always_comb begin
		env_rd = evld_s1 ? ram_rdata : '0;
		attack = (mag_s1 > env_rd);
		diff = env_rd - mag_s1;
	end

	// Release step is the ceiling of coef*(env-x)/2^COEF_BITS, never more than env-x.
	always_comb begin
		prod = (COEF_BITS+SAMPLE_BITS)'(release_coef) * (COEF_BITS+SAMPLE_BITS)'(diff_s2);
		step = prod[COEF_BITS+SAMPLE_BITS-1:COEF_BITS] +
			SAMPLE_BITS'(prod[COEF_BITS-1:0] != '0);
		env_new = attack_s2 ? mag_s2 : env_s2 - step;
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			chan_s1 <= head_chan;
			idx_s1 <= head_idx;
			mag_s1 <= head_mag;
			ok_s1 <= head_ok;
			evld_s1 <= head_ok && env_vld_q[head_idx];
		end
		if (adv_s1) begin
			chan_s2 <= chan_s1;
			idx_s2 <= idx_s1;
			mag_s2 <= mag_s1;
			ok_s2 <= ok_s1;
			attack_s2 <= attack;
			env_s2 <= env_rd;
			diff_s2 <= diff;
		end
		if (adv_s2) begin
			out_chan_q <= chan_s2;
			level_q <= ok_s2 ? env_new : '0;
			chan_valid_q <= ok_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			result_vld_q <= 1'b0;
			env_vld_q <= '0;
		end else begin
			if (s1_free) begin
				vld_s1 <= issue;
			end
			if (s2_free) begin
				vld_s2 <= vld_s1;
			end
			if (out_free) begin
				result_vld_q <= vld_s2;
			end
			if (ram_we) begin
				env_vld_q[idx_s2] <= 1'b1;
			end
		end
	end

	assign result_valid = result_vld_q;
	assign out_chan = out_chan_q;
	assign level = level_q;
	assign chan_valid = chan_valid_q;

	`PME_ASSERT_SAME(a_no_rw_collision, ram_we && ram_re, idx_s2 != head_idx, "envelope read and write collide")
	`PME_ASSERT_NEXT(a_issue_fills_s1, issue, vld_s1, "issued item did not reach the first stage")
	`PME_ASSERT_SAME(a_env_not_below_mag, vld_s2 && ok_s2, env_new >= mag_s2, "envelope fell below magnitude")
	`PME_ASSERT_SAME(a_reject_zero_level, result_vld_q && !chan_valid_q, level_q == '0, "rejected channel has a level")

endmodule

// File: rtl/peak_meter_envelope_unit.sv
// Each sample is registered in the queue, both envelope stages and the output register.
// Throughput: one sample per cycle with no output stall and no channel repeat in three consecutive samples.
// A sample whose channel is still in the two-stage envelope update waits until that update leaves both stages.
// Reset clears all envelopes through per-channel valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
// Peak meter envelope unit
// Multichannel peak meter envelope follower with instant attack and
// exponential release, one envelope per channel.
// ----------------------------------------------------------------------------
module peak_meter_envelope_unit import pme_pkg::*; #(
	parameter int CHANNELS = DEF_CHANNELS,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int COEF_BITS = DEF_COEF_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [COEF_BITS-1:0]   cfg_data,
	input  logic                   sample_valid,
	output logic                   sample_ready,
	input  logic [CHAN_W-1:0]      chan,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   result_valid,
	input  logic                   result_ready,
	output logic [CHAN_W-1:0]      out_chan,
	output logic [SAMPLE_BITS-1:0] level,
	output logic                   chan_valid
);

	localparam int QW = CHAN_W + SAMPLE_BITS + 1;

	logic [ACT_W-1:0]       active_channels_q;
	logic [COEF_BITS-1:0]   release_coef_q;
	logic                   push;
	logic                   push_ready;
	logic [CHAN_W-1:0]      push_chan;
	logic [SAMPLE_BITS-1:0] push_mag;
	logic                   push_ok;
	logic                   pop;
	logic                   head_valid;
	logic [QW-1:0]          head_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_channels_q <= ACTIVE_CHANNELS_RESET;
			release_coef_q <= COEF_BITS'(RELEASE_COEF_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ACTIVE_CHANNELS: active_channels_q <= cfg_data[ACT_W-1:0];
				CFG_RELEASE_COEF: release_coef_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pme_front #(
		.CHANNELS(CHANNELS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.chan(chan),
		.sample(sample),
		.active_channels(active_channels_q),
		.push_ready(push_ready),
		.push(push),
		.push_chan(push_chan),
		.push_mag(push_mag),
		.push_ok(push_ok)
	);

	pme_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data({push_chan, push_mag, push_ok}),
		.push_ready(push_ready),
		.pop(pop),
		.head_valid(head_valid),
		.head_data(head_data)
	);

	pme_back #(
		.CHANNELS(CHANNELS),
		.SAMPLE_BITS(SAMPLE_BITS),
		.COEF_BITS(COEF_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_chan(head_data[QW-1:SAMPLE_BITS+1]),
		.head_mag(head_data[SAMPLE_BITS:1]),
		.head_ok(head_data[0]),
		.pop(pop),
		.release_coef(release_coef_q),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.out_chan(out_chan),
		.level(level),
		.chan_valid(chan_valid)
	);

endmodule
